// File: sv/assert_macros.svh
// Assertion macros used by the frame timing sequencer top level.
// Expects clk and rst (synchronous, active high) in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define AST_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define AST_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: sv/fts_pkg.sv
// Frame timing sequencer package: widths, op and status codes, FSM states,
// and the command/status structs between controller and datapath.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package fts_pkg;

  localparam int MAX_FRAMES = 256;
  localparam int POS_W      = 8;
  localparam int CNT_W      = 9;
  localparam int DUR_W      = 16;
  localparam int DELTA_W    = 16;
  localparam int STEP_W     = 10;
  localparam int ELAPSED_W  = 25;

  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;

  localparam logic [0:0] CFG_FRAME_COUNT = 1'b0;
  localparam logic [0:0] CFG_LOOPING     = 1'b1;

  typedef enum logic [2:0] {
    OP_TICK      = 3'd0,
    OP_PLAY      = 3'd1,
    OP_PAUSE     = 3'd2,
    OP_STOP      = 3'd3,
    OP_RESTART   = 3'd4,
    OP_STEP      = 3'd5,
    OP_REVERSE   = 3'd6,
    OP_WRITE_DUR = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    ST_STOPPED   = 2'd0,
    ST_PLAYING   = 2'd1,
    ST_PAUSED    = 2'd2,
    ST_COMPLETED = 2'd3
  } play_status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_WALK,
    S_STEP,
    S_FINISH
  } fsm_state_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic walk;
    logic step_one;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic empty;
    logic playing;
    logic walk_end;
    logic step_none;
    logic step_last;
  } sts_t;

endpackage
`default_nettype wire

// File: sv/fts_ctrl.sv
// Frame timing sequencer controller: handshakes and the sequencing FSM.
// Depends on fts_pkg.
`timescale 1ns / 1ps
`default_nettype none
module fts_ctrl
  import fts_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  wire logic out_ready,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  fsm_state_t state, state_next;
  logic       out_free;

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_EXEC;
      end
      S_EXEC: begin
        priority if (sts.op == OP_TICK && sts.playing && !sts.empty) begin
          state_next = S_WALK;
        end else if (sts.op == OP_STEP && !sts.empty && !sts.step_none) begin
          state_next = S_STEP;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_WALK: begin
        if (sts.walk_end) state_next = S_FINISH;
      end
      S_STEP: begin
        if (sts.step_last) state_next = S_FINISH;
      end
      S_FINISH: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_EXEC:   cmd.exec     = 1'b1;
      S_WALK:   cmd.walk     = 1'b1;
      S_STEP:   cmd.step_one = 1'b1;
      S_FINISH: cmd.out_load = out_free;
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule
`default_nettype wire

// File: sv/fts_datapath.sv
// Frame timing sequencer datapath: config, player state, duration table,
// tick walk and step arithmetic, result register.
// Depends on fts_pkg; driven by fts_ctrl commands.
`timescale 1ns / 1ps
`default_nettype none
module fts_datapath
  import fts_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_write,
  input  wire logic [0:0]            cfg_index,
  input  wire logic [CNT_W-1:0]      cfg_data,
  input  wire logic [2:0]            op,
  input  wire logic [DELTA_W-1:0]    delta_time,
  input  wire logic signed [STEP_W-1:0] step_count,
  input  wire logic                  reverse_value,
  input  wire logic [POS_W-1:0]      table_index,
  input  wire logic [DUR_W-1:0]      duration_value,
  input  wire cmd_t                  cmd,
  output sts_t                       sts,
  output logic [POS_W-1:0]           frame_index,
  output logic [1:0]                 status,
  output logic [ELAPSED_W-1:0]       elapsed_time
);

  // config
  logic [CNT_W-1:0] frame_count;
  logic             looping;

  // player state
  play_status_t       pstat, pstat_next;
  logic [POS_W-1:0]   position, position_next;
  logic [ELAPSED_W-1:0] elapsed, elapsed_next;
  logic               reverse_flag, reverse_next;
  logic [CNT_W-1:0]   zero_runs, zero_runs_next;
  logic [STEP_W-1:0]  step_cnt, step_cnt_next;

  // latched beat
  op_t                op_q;
  logic [DELTA_W-1:0] delta_q;
  logic [STEP_W-1:0]  sc_q;
  logic               rev_q;
  logic [POS_W-1:0]   tix_q;
  logic [DUR_W-1:0]   dur_q;

  // duration table
  logic [DUR_W-1:0] mem [MAX_FRAMES];
  logic [DUR_W-1:0] rd_data;

  logic [CNT_W-1:0]     n;
  logic [POS_W-1:0]     n_last, first_cur, first_new;
  logic [POS_W-1:0]     fwd_pos, back_pos;
  logic                 fwd_done;
  logic [ELAPSED_W:0]   sum;
  logic [ELAPSED_W-1:0] el_sat, dur_ext;
  logic                 dur_zero, el_ge;
  logic [CNT_W-1:0]     zr_inc;
  logic [STEP_W-1:0]    step_mag;
  logic                 walk_end;

  assign n         = (frame_count > CNT_W'(MAX_FRAMES)) ? CNT_W'(MAX_FRAMES) : frame_count;
  assign n_last    = POS_W'(n - CNT_W'(1));
  assign first_cur = (reverse_flag && n != '0) ? n_last : '0;
  assign first_new = (rev_q && n != '0) ? n_last : '0;

  always_comb begin
    fwd_pos  = position;
    fwd_done = 1'b0;
    if (reverse_flag) begin
      priority if (position != '0) fwd_pos = position - POS_W'(1);
      else if (looping)            fwd_pos = n_last;
      else                         fwd_done = 1'b1;
    end else begin
      priority if (({1'b0, position} + CNT_W'(1)) < n) fwd_pos = position + POS_W'(1);
      else if (looping)                                fwd_pos = '0;
      else                                             fwd_done = 1'b1;
    end
  end

  always_comb begin
    if (reverse_flag) begin
      back_pos = (({1'b0, position} + CNT_W'(1)) < n) ? position + POS_W'(1) : '0;
    end else begin
      back_pos = (position != '0) ? position - POS_W'(1) : n_last;
    end
  end

  assign sum      = {1'b0, elapsed} + (ELAPSED_W+1)'(delta_q);
  assign el_sat   = sum[ELAPSED_W] ? ELAPSED_MAX : sum[ELAPSED_W-1:0];
  assign dur_ext  = ELAPSED_W'({rd_data, 8'h00});
  assign dur_zero = (rd_data == '0);
  assign el_ge    = (elapsed >= dur_ext);
  assign zr_inc   = zero_runs + CNT_W'(1);
  assign step_mag = sc_q[STEP_W-1] ? STEP_W'(-sc_q) : sc_q;

  always_comb begin
    priority if (dur_zero) walk_end = fwd_done || (zr_inc > n);
    else if (!el_ge)       walk_end = 1'b1;
    else                   walk_end = fwd_done;
  end

  always_comb begin
    pstat_next     = pstat;
    position_next  = position;
    elapsed_next   = elapsed;
    reverse_next   = reverse_flag;
    zero_runs_next = zero_runs;
    step_cnt_next  = step_cnt;
    priority if (cmd.exec) begin
      unique case (op_q)
        OP_TICK: begin
          zero_runs_next = '0;
          if (pstat == ST_PLAYING && n != '0) elapsed_next = el_sat;
        end
        OP_PLAY: begin
          if (n != '0) begin
            if (pstat == ST_COMPLETED) begin
              position_next = first_cur;
              elapsed_next  = '0;
            end
            pstat_next = ST_PLAYING;
          end
        end
        OP_PAUSE: begin
          if (pstat == ST_PLAYING) pstat_next = ST_PAUSED;
        end
        OP_STOP: begin
          pstat_next    = ST_STOPPED;
          position_next = first_cur;
          elapsed_next  = '0;
        end
        OP_RESTART: begin
          pstat_next    = ST_PLAYING;
          position_next = first_cur;
          elapsed_next  = '0;
        end
        OP_STEP: begin
          step_cnt_next = step_mag;
          if (n != '0) elapsed_next = '0;
        end
        OP_REVERSE: begin
          if (rev_q != reverse_flag) begin
            reverse_next = rev_q;
            if (pstat == ST_STOPPED || pstat == ST_COMPLETED) begin
              position_next = first_new;
              elapsed_next  = '0;
            end
          end
        end
        OP_WRITE_DUR: begin
        end
        default: begin
        end
      endcase
    end else if (cmd.walk) begin
      if (dur_zero) begin
        position_next  = fwd_pos;
        zero_runs_next = zr_inc;
        if (fwd_done) pstat_next = ST_COMPLETED;
      end else if (el_ge) begin
        elapsed_next  = elapsed - dur_ext;
        position_next = fwd_pos;
        if (fwd_done) pstat_next = ST_COMPLETED;
      end
    end else if (cmd.step_one) begin
      step_cnt_next = step_cnt - STEP_W'(1);
      if (sc_q[STEP_W-1]) begin
        position_next = back_pos;
      end else begin
        position_next = fwd_pos;
        if (fwd_done) pstat_next = ST_COMPLETED;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_count  <= '0;
      looping      <= 1'b0;
      pstat        <= ST_STOPPED;
      position     <= '0;
      elapsed      <= '0;
      reverse_flag <= 1'b0;
      zero_runs    <= '0;
      step_cnt     <= '0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          CFG_FRAME_COUNT: frame_count <= cfg_data;
          CFG_LOOPING:     looping     <= cfg_data[0];
          default: begin
          end
        endcase
      end
      pstat        <= pstat_next;
      position     <= position_next;
      elapsed      <= elapsed_next;
      reverse_flag <= reverse_next;
      zero_runs    <= zero_runs_next;
      step_cnt     <= step_cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q    <= op_t'(op);
      delta_q <= delta_time;
      sc_q    <= step_count;
      rev_q   <= reverse_value;
      tix_q   <= table_index;
      dur_q   <= duration_value;
    end
    if (cmd.out_load) begin
      frame_index  <= position;
      status       <= pstat;
      elapsed_time <= elapsed;
    end
  end

  // read follows the next position so rd_data matches the current frame
  always_ff @(posedge clk) begin
    if (cmd.exec && op_q == OP_WRITE_DUR) mem[tix_q] <= dur_q;
    rd_data <= mem[position_next];
  end

  always_comb begin
    sts.op        = op_q;
    sts.empty     = (n == '0);
    sts.playing   = (pstat == ST_PLAYING);
    sts.walk_end  = walk_end;
    sts.step_none = (step_mag == '0);
    sts.step_last = (step_cnt == STEP_W'(1));
  end

endmodule
`default_nettype wire

// File: sv/frame_timing_sequencer_top.sv
// Frame timing sequencer top level: controller plus datapath, port checks.
// Depends on fts_pkg, fts_ctrl, fts_datapath and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
// Sprite frame sequencer with stopped/playing/paused/completed states and a
// 256-entry frame duration table. Every input beat gives one result beat.
// Simple ops pass through accept, execute and result load. A tick that walks
// frames adds a walk step for each table entry the walk visits: one table
// read per cycle. A step on a non-empty sequence adds |step_count| frame moves,
// one frame move per cycle. The result register lets the next beat be
// accepted while the previous result waits. Durations read before being
// written are undefined.
module frame_timing_sequencer_top
  import fts_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     cfg_write,
  input  wire logic [0:0]               cfg_index,
  input  wire logic [CNT_W-1:0]         cfg_data,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic [2:0]               op,
  input  wire logic [DELTA_W-1:0]       delta_time,
  input  wire logic signed [STEP_W-1:0] step_count,
  input  wire logic                     reverse_value,
  input  wire logic [POS_W-1:0]         table_index,
  input  wire logic [DUR_W-1:0]         duration_value,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic [POS_W-1:0]              frame_index,
  output logic [1:0]                    status,
  output logic [ELAPSED_W-1:0]          elapsed_time
);

  cmd_t cmd;
  sts_t sts;

  fts_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  fts_datapath u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .op             (op),
    .delta_time     (delta_time),
    .step_count     (step_count),
    .reverse_value  (reverse_value),
    .table_index    (table_index),
    .duration_value (duration_value),
    .cmd            (cmd),
    .sts            (sts),
    .frame_index    (frame_index),
    .status         (status),
    .elapsed_time   (elapsed_time)
  );

  `AST_SAME(a_walk_playing, cmd.walk, sts.playing)
  `AST_SAME(a_step_nonempty, cmd.step_one, !sts.empty)
  `AST_NEXT(a_accept_busy, in_valid && in_ready, !in_ready)
  `AST_NEXT(a_load_valid, cmd.out_load, out_valid)

endmodule
`default_nettype wire
